[rtl/ebg_pkg.sv]
`timescale 1ns / 1ps

package ebg_pkg;

    localparam int TABLE_ROWS_DEF = 256;
    localparam int ROW_LENGTH_DEF = 64;

    localparam int GRAD_W = 48;
    localparam int PROD_W = 32;
    localparam int ROW_W  = 8;
    localparam int FEAT_W = 6;
    localparam int ELEM_W = 16;
    localparam int BAG_W  = 7;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;
    localparam int DIV_CNT_W   = 6;

    typedef enum logic
    {
        OP_ACCUMULATE = 1'b0,
        OP_READ       = 1'b1
    } ebg_op_t;

    typedef enum logic
    {
        KIND_WEIGHT = 1'b0,
        KIND_TABLE  = 1'b1
    } ebg_kind_t;

    typedef enum logic
    {
        REG_BAG_SIZE  = 1'b0,
        REG_MEAN_MODE = 1'b1
    } ebg_reg_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } ebg_state_t;

    // control strobes from the sequencer
    typedef struct packed
    {
        logic in_ready;
        logic mem_we;
        logic clear_we;
        logic div_start;
        logic div_step;
        logic out_load;
    } ebg_ctrl_t;

    function automatic logic signed [GRAD_W-1:0] sat_add48(
        input logic signed [GRAD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [GRAD_W:0] sum;
        logic signed [GRAD_W-1:0] res;
        sum = {a[GRAD_W-1], a} + {{(GRAD_W-PROD_W+1){b[PROD_W-1]}}, b};
        if (sum[GRAD_W] != sum[GRAD_W-1])
        begin
            res = sum[GRAD_W] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
        end
        else
        begin
            res = sum[GRAD_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/embedding_bag_gradient_core.sv]
`timescale 1ns / 1ps

// Weighted embedding-bag backward core, Q8.8 in, Q32.16 out, 48-bit saturating sums.
// Accumulate items (tuser 0) add param*loss into a running dot product, emitted as a
// weight gradient on the item with tlast, and add weight*loss into the table gradient
// store entry (row, feature). Read items (tuser 1) return one store entry and clear it.
// The store is a single-port-write, registered-read memory of TABLE_ROWS*ROW_LENGTH
// entries; each item is a read-modify-write of one entry, so one item is in flight at
// a time. An item without a result goes from update back to idle; an item with a result
// goes from update to the output state, through the bit-serial divider first when mean
// mode is on and bag_size is above 1, and the next item is taken only after the output
// state has loaded the result, which waits while an earlier result waits on m_axis_tready.
// After reset the store is swept to zero, one entry per cycle over all TABLE_ROWS*ROW_LENGTH
// entries (16384 by default); no item is taken during the sweep, while configuration
// writes are. Configuration must be written only while idle; the block itself does not enforce this.
module embedding_bag_gradient_core #(
    parameter int TABLE_ROWS = ebg_pkg::TABLE_ROWS_DEF,
    parameter int ROW_LENGTH = ebg_pkg::ROW_LENGTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // row_index[7:0], feature[13:8], param_value[29:14], loss_grad[45:30],
    // bag_weight[61:46], zero[63:62]
    input  logic [ebg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // gradient[47:0], out_row[55:48], out_feature[61:56], zero[63:62]
    output logic [ebg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_kind
    output logic                               m_axis_tuser,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [ebg_pkg::BAG_W-1:0]          cfg_data
);

    localparam int StoreDepth = TABLE_ROWS * ROW_LENGTH;
    localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
    localparam int GradW      = ebg_pkg::GRAD_W;

    typedef struct packed
    {
        ebg_pkg::ebg_op_t              op;
        logic [ebg_pkg::ROW_W-1:0]     row;
        logic [ebg_pkg::FEAT_W-1:0]    feature;
        logic                          last;
        logic                          in_range;
        logic [AddrW-1:0]              addr;
    } item_t;

    // input unpacking
    logic [ebg_pkg::ROW_W-1:0]           in_row;
    logic [ebg_pkg::FEAT_W-1:0]          in_feature;
    logic signed [ebg_pkg::ELEM_W-1:0]   in_param;
    logic signed [ebg_pkg::ELEM_W-1:0]   in_loss;
    logic signed [ebg_pkg::ELEM_W-1:0]   in_weight;
    logic [31:0]                         in_addr_full;
    logic                                in_range;
    logic                                in_accept;

    assign in_row     = s_axis_tdata[7:0];
    assign in_feature = s_axis_tdata[13:8];
    assign in_param   = s_axis_tdata[29:14];
    assign in_loss    = s_axis_tdata[45:30];
    assign in_weight  = s_axis_tdata[61:46];
    assign in_addr_full = 32'(in_row) * 32'(ROW_LENGTH) + 32'(in_feature);
    assign in_range   = (32'(in_row) < 32'(TABLE_ROWS)) && (32'(in_feature) < 32'(ROW_LENGTH));
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    // registers
    ebg_pkg::ebg_state_t                 state_reg, state_next;
    ebg_pkg::ebg_ctrl_t                  ctrl;
    item_t                               item_reg;
    logic signed [ebg_pkg::PROD_W-1:0]   prod_pg_reg;
    logic signed [ebg_pkg::PROD_W-1:0]   prod_wg_reg;
    logic signed [GradW-1:0]             dot_acc_reg;
    logic [GradW-1:0]                    mem_rdata_reg;
    logic [AddrW-1:0]                    clr_addr_reg;
    logic [ebg_pkg::BAG_W-1:0]           bag_size_reg;
    logic                                mean_mode_reg;
    logic signed [GradW-1:0]             res_value_reg;
    logic [GradW-1:0]                    div_quot_reg;
    logic [ebg_pkg::BAG_W-1:0]           div_rem_reg;
    logic [ebg_pkg::DIV_CNT_W-1:0]       div_cnt_reg;
    logic                                div_neg_reg;
    logic                                m_valid_reg;
    ebg_pkg::ebg_kind_t                  m_kind_reg;
    logic [GradW-1:0]                    m_grad_reg;
    logic [ebg_pkg::ROW_W-1:0]           m_row_reg;
    logic [ebg_pkg::FEAT_W-1:0]          m_feat_reg;

    logic [GradW-1:0] store_mem [StoreDepth];

    // update-stage arithmetic
    logic signed [GradW-1:0]             dot_sum;
    logic signed [GradW-1:0]             store_sum;
    logic signed [GradW-1:0]             result_value;
    logic                                has_result;
    logic                                need_divide;
    logic [GradW-1:0]                    result_mag;
    logic [AddrW-1:0]                    mem_waddr;
    logic [GradW-1:0]                    mem_wdata;
    logic                                clear_done;
    logic                                div_last;

    // divider step
    logic [ebg_pkg::BAG_W:0]             div_trial;
    logic                                div_ge;
    logic [ebg_pkg::BAG_W-1:0]           div_rem_next;
    logic [GradW-1:0]                    div_quot_next;
    logic [GradW-1:0]                    div_signed_res;

    assign dot_sum    = ebg_pkg::sat_add48(dot_acc_reg, prod_pg_reg);
    assign store_sum  = ebg_pkg::sat_add48(mem_rdata_reg, prod_wg_reg);
    assign has_result = (item_reg.op == ebg_pkg::OP_READ) || item_reg.last;
    assign need_divide = mean_mode_reg && (bag_size_reg > ebg_pkg::BAG_W'(1));
    assign clear_done = (clr_addr_reg == AddrW'(StoreDepth - 1));
    assign div_last   = (div_cnt_reg == ebg_pkg::DIV_CNT_W'(GradW - 1));

    always_comb
    begin
        if (item_reg.op == ebg_pkg::OP_ACCUMULATE)
        begin
            result_value = dot_sum;
        end
        else if (item_reg.in_range)
        begin
            result_value = mem_rdata_reg;
        end
        else
        begin
            result_value = '0;
        end
        result_mag = result_value[GradW-1] ? (GradW'(0) - result_value) : result_value;
    end

    always_comb
    begin
        div_trial     = {div_rem_reg, div_quot_reg[GradW-1]};
        div_ge        = (div_trial >= {1'b0, bag_size_reg});
        div_rem_next  = div_ge ? ebg_pkg::BAG_W'(div_trial - {1'b0, bag_size_reg})
                               : div_trial[ebg_pkg::BAG_W-1:0];
        div_quot_next = {div_quot_reg[GradW-2:0], div_ge};
        div_signed_res = div_neg_reg ? (GradW'(0) - div_quot_next) : div_quot_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ebg_pkg::ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ebg_pkg::ST_IDLE;
                end
            end
            ebg_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ebg_pkg::ST_UPDATE;
                end
            end
            ebg_pkg::ST_UPDATE:
            begin
                if (!has_result)
                begin
                    state_next = ebg_pkg::ST_IDLE;
                end
                else if (need_divide)
                begin
                    state_next = ebg_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = ebg_pkg::ST_OUTPUT;
                end
            end
            ebg_pkg::ST_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = ebg_pkg::ST_OUTPUT;
                end
            end
            ebg_pkg::ST_OUTPUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ebg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ebg_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ebg_pkg::ST_CLEAR:
            begin
                ctrl.clear_we = 1'b1;
            end
            ebg_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ebg_pkg::ST_UPDATE:
            begin
                ctrl.mem_we    = item_reg.in_range;
                ctrl.div_start = has_result && need_divide;
            end
            ebg_pkg::ST_DIVIDE:
            begin
                ctrl.div_step = 1'b1;
            end
            ebg_pkg::ST_OUTPUT:
            begin
                ctrl.out_load = !m_valid_reg || m_axis_tready;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign mem_waddr = ctrl.clear_we ? clr_addr_reg : item_reg.addr;
    always_comb
    begin
        if (ctrl.clear_we || item_reg.op == ebg_pkg::OP_READ)
        begin
            mem_wdata = '0;
        end
        else
        begin
            mem_wdata = store_sum;
        end
    end

    // store: one write port, registered read; the write of an item lands before
    // the next item is accepted, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_we || ctrl.clear_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[in_addr_full[AddrW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ebg_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            dot_acc_reg   <= '0;
            bag_size_reg  <= ebg_pkg::BAG_W'(1);
            mean_mode_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.clear_we)
            begin
                clr_addr_reg <= clr_addr_reg + AddrW'(1);
            end
            if (cfg_valid)
            begin
                case (ebg_pkg::ebg_reg_t'(cfg_index))
                    ebg_pkg::REG_BAG_SIZE:  bag_size_reg  <= cfg_data;
                    ebg_pkg::REG_MEAN_MODE: mean_mode_reg <= cfg_data[0];
                    default:                bag_size_reg  <= bag_size_reg;
                endcase
            end
            if (state_reg == ebg_pkg::ST_UPDATE && item_reg.op == ebg_pkg::OP_ACCUMULATE)
            begin
                dot_acc_reg <= item_reg.last ? '0 : dot_sum;
            end
            if (ctrl.div_start)
            begin
                div_cnt_reg <= '0;
            end
            else if (ctrl.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + ebg_pkg::DIV_CNT_W'(1);
            end
            if (ctrl.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.op       <= ebg_pkg::ebg_op_t'(s_axis_tuser);
            item_reg.row      <= in_row;
            item_reg.feature  <= in_feature;
            item_reg.last     <= s_axis_tlast;
            item_reg.in_range <= in_range;
            item_reg.addr     <= in_addr_full[AddrW-1:0];
            prod_pg_reg       <= ebg_pkg::PROD_W'(in_param) * ebg_pkg::PROD_W'(in_loss);
            prod_wg_reg       <= ebg_pkg::PROD_W'(in_weight) * ebg_pkg::PROD_W'(in_loss);
        end
        if (state_reg == ebg_pkg::ST_UPDATE)
        begin
            res_value_reg <= result_value;
        end
        if (ctrl.div_start)
        begin
            div_quot_reg <= result_mag;
            div_rem_reg  <= '0;
            div_neg_reg  <= result_value[GradW-1];
        end
        else if (ctrl.div_step)
        begin
            div_quot_reg <= div_quot_next;
            div_rem_reg  <= div_rem_next;
            if (div_last)
            begin
                res_value_reg <= div_signed_res;
            end
        end
        if (ctrl.out_load)
        begin
            m_kind_reg <= (item_reg.op == ebg_pkg::OP_READ) ? ebg_pkg::KIND_TABLE
                                                            : ebg_pkg::KIND_WEIGHT;
            m_grad_reg <= res_value_reg;
            m_row_reg  <= item_reg.row;
            m_feat_reg <= (item_reg.op == ebg_pkg::OP_READ) ? item_reg.feature : '0;
        end
    end

    assign s_axis_tready = ctrl.in_ready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = {2'b00, m_feat_reg, m_row_reg, m_grad_reg};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ebg_pkg::ST_UPDATE)
        else $error("accepted item did not enter update");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ebg_pkg::ST_CLEAR |-> !m_axis_tvalid)
        else $error("result presented during store clearing");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ebg_pkg::ST_DIVIDE |-> div_rem_reg < bag_size_reg)
        else $error("divider remainder not below divisor");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ebg_pkg::KIND_WEIGHT) |-> m_axis_tdata[61:56] == '0)
        else $error("weight gradient with nonzero feature");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ebg_pkg::ST_UPDATE && item_reg.op == ebg_pkg::OP_ACCUMULATE
         && item_reg.last) |=> dot_acc_reg == '0)
        else $error("dot product not cleared after last feature");
`endif

endmodule
